@@ rtl/core/bblur_pkg.sv @@
// ----------------------------------------------------------------------------
// bblur_pkg
// Shared types and constants for the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bblur_pkg;

  localparam int PIX_W  = 24;   // three 8-bit channels
  localparam int SUM_W  = 12;   // 3x3 sum of one channel, max 2295

  localparam int QUEUE_DEPTH = 4;
  localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  // Window sums for one result, passed from front to back.
  typedef struct packed {
    logic             last;
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_item_t;

endpackage

@@ rtl/core/bblur_ram.sv @@
// ----------------------------------------------------------------------------
// bblur_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bblur_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/bblur_front.sv @@
// ----------------------------------------------------------------------------
// bblur_front
// Raster position tracking, line stores, column sums and window sums.
// ----------------------------------------------------------------------------
module bblur_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [11:0]                   cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [bblur_pkg::PIX_W-1:0]   s_tdata,
  input  logic                          s_tuser,
  input  logic [bblur_pkg::QLVL_W-1:0]  q_level,
  output logic                          push,
  output bblur_pkg::sum_item_t          push_item
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = 13;
  localparam int CSUM_W = 10;
  localparam logic [10:0] WIDTH_RESET  = 11'd800;
  localparam logic [11:0] HEIGHT_RESET = 12'd600;
  localparam logic [12:0] MAX_W        = 13'(MAX_WIDTH);

  logic [10:0]      frame_width;
  logic [11:0]      frame_height;
  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;

  logic [COL_W-1:0] w_last;
  logic [11:0]      h_eff;
  logic [ROW_W-1:0] h_ext;
  logic [ROW_W-1:0] h_plus1;
  logic             accept;
  logic             pend;
  logic [bblur_pkg::QLVL_W:0] busy;
  logic             at_col0;
  logic             emit_now;
  logic             last_now;
  logic [bblur_pkg::PIX_W-1:0] incoming;

  // item in flight while the line stores answer
  logic                        s1_valid;
  logic [COL_W-1:0]            s1_col;
  logic                        s1_col0;
  logic                        s1_emit;
  logic                        s1_last;
  logic                        s1_top_ok;
  logic                        s1_mid_ok;
  logic [bblur_pkg::PIX_W-1:0] s1_pix;

  logic [bblur_pkg::PIX_W-1:0] up_rdata;
  logic [bblur_pkg::PIX_W-1:0] mid_rdata;

  logic [CSUM_W-1:0]            colsum [3];
  logic [CSUM_W-1:0]            prev   [3];
  logic [CSUM_W-1:0]            prev2  [3];
  logic [bblur_pkg::SUM_W-1:0]  total  [3];

  always_comb begin
    if (frame_width < 11'd3) begin
      w_last = COL_W'(2);
    end else if ({2'b00, frame_width} > MAX_W) begin
      w_last = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last = COL_W'({2'b00, frame_width} - 13'd1);
    end
    h_eff   = (frame_height < 12'd3) ? 12'd3 : frame_height;
    h_ext   = {1'b0, h_eff};
    h_plus1 = h_ext + 13'd1;
  end

  // leave room in the queue for the item still in flight
  assign pend     = s1_valid && s1_emit;
  assign busy     = {1'b0, q_level} + {{bblur_pkg::QLVL_W{1'b0}}, pend};
  assign s_tready = busy < (bblur_pkg::QLVL_W + 1)'(bblur_pkg::QUEUE_DEPTH);
  assign accept   = s_tvalid && s_tready;

  // center sits one column back, or at the end of the row before last at column 0
  always_comb begin
    at_col0  = (col == '0);
    emit_now = at_col0 ? (row >= 13'd2 && row <= h_plus1)
                       : (row >= 13'd1 && row <= h_ext);
    last_now = at_col0 && (row == h_plus1);
    incoming = (!s_tuser && row < h_ext) ? s_tdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      s1_valid     <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (cfg_we) begin
        unique case (cfg_index)
          bblur_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
          bblur_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
          default: ;
        endcase
        col <= '0;
        row <= '0;
      end else if (accept) begin
        priority if (last_now) begin
          col <= '0;
          row <= '0;
        end else if (col == w_last) begin
          col <= '0;
          row <= row + 13'd1;
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= col;
      s1_col0   <= at_col0;
      s1_emit   <= emit_now;
      s1_last   <= last_now;
      s1_top_ok <= row >= 13'd2;
      s1_mid_ok <= row >= 13'd1;
      s1_pix    <= incoming;
    end
  end

  // upper row store takes the old middle row entry, middle takes the new pixel
  bblur_ram #(.WIDTH(bblur_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid_rdata),
    .re    (accept),
    .raddr (col),
    .rdata (up_rdata)
  );

  bblur_ram #(.WIDTH(bblur_pkg::PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (accept),
    .raddr (col),
    .rdata (mid_rdata)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      colsum[j] = (s1_top_ok ? CSUM_W'(up_rdata[8*j +: 8]) : '0)
                + (s1_mid_ok ? CSUM_W'(mid_rdata[8*j +: 8]) : '0)
                + CSUM_W'(s1_pix[8*j +: 8]);
      // at column 0 the right neighbor column lies outside the frame
      total[j]  = bblur_pkg::SUM_W'(prev2[j])
                + bblur_pkg::SUM_W'(prev[j])
                + (s1_col0 ? '0 : bblur_pkg::SUM_W'(colsum[j]));
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int j = 0; j < 3; j++) begin
        prev2[j] <= s1_col0 ? '0 : prev[j];
        prev[j]  <= colsum[j];
      end
    end
  end

  assign push            = s1_valid && s1_emit;
  assign push_item.last  = s1_last;
  assign push_item.red   = total[0];
  assign push_item.green = total[1];
  assign push_item.blue  = total[2];

endmodule

@@ rtl/core/bblur_queue.sv @@
// ----------------------------------------------------------------------------
// bblur_queue
// Short register FIFO of window sums between front and back.
// ----------------------------------------------------------------------------
module bblur_queue (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  bblur_pkg::sum_item_t          push_item,
  input  logic                          pop,
  output logic                          q_valid,
  output bblur_pkg::sum_item_t          q_item,
  output logic [bblur_pkg::QLVL_W-1:0]  level
);

  bblur_pkg::sum_item_t              entries [bblur_pkg::QUEUE_DEPTH];
  logic [bblur_pkg::QPTR_W-1:0]      wr_ptr;
  logic [bblur_pkg::QPTR_W-1:0]      rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bblur_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bblur_pkg::QPTR_W'(1);
      end
      level <= level + bblur_pkg::QLVL_W'(push) - bblur_pkg::QLVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign q_valid = (level != '0);
  assign q_item  = entries[rd_ptr];

endmodule

@@ rtl/core/bblur_back.sv @@
// ----------------------------------------------------------------------------
// bblur_back
// Divide window sums by 9, pack the pixel word, hold it for the sink.
// ----------------------------------------------------------------------------
module bblur_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  bblur_pkg::sum_item_t  q_item,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,
  output logic                  m_tlast
);

  // floor(x*7282/65536) == floor(x/9) for every x up to 2295
  localparam logic [12:0] DIV9_MUL = 13'd7282;
  localparam logic [7:0]  ALPHA    = 8'hFF;

  function automatic logic [7:0] div9(input logic [bblur_pkg::SUM_W-1:0] x);
    logic [24:0] prod;
    prod = 25'(x) * 25'(DIV9_MUL);
    return prod[23:16];
  endfunction

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {div9(q_item.red), div9(q_item.green), div9(q_item.blue), ALPHA};
      m_tlast <= q_item.last;
    end
  end

endmodule

@@ rtl/core/box_blur_3x3_rgb.sv @@
// A completed window's sums pass the in-flight stage and the queue before reaching the output register.
// Results trail pixels by frame width + 1 items; width + 1 drain items flush a frame.
// Throughput: one item per cycle while the queue has room, set by the line-store read/write-back each cycle.
// A 4-entry queue and an output register absorb sink stalls.
// Reset (synchronous, rst high): position, queue and output valid clear; size 800x600.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// Streaming 3x3 box blur over RGB frames with zero outside the frame.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // in_red[7:0], in_green[15:8], in_blue[23:16]
  input  logic        s_tuser,   // drain
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // pixel_word[31:0]
  output logic        m_tlast    // last_of_frame
);

  logic                          push;
  bblur_pkg::sum_item_t          push_item;
  logic                          q_valid;
  bblur_pkg::sum_item_t          q_item;
  logic                          q_pop;
  logic [bblur_pkg::QLVL_W-1:0]  q_level;

  bblur_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_level   (q_level),
    .push      (push),
    .push_item (push_item)
  );

  bblur_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .level     (q_level)
  );

  bblur_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

`ifndef ASSERT_OFF
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_level <= bblur_pkg::QLVL_W'(bblur_pkg::QUEUE_DEPTH))
    else $error("window sum queue over capacity");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (q_level == bblur_pkg::QLVL_W'(bblur_pkg::QUEUE_DEPTH)) |-> !s_tready)
    else $error("input open while queue full");

  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_level != '0))
    else $error("pop from empty queue");

  a_full_stays_without_pop: assert property (@(posedge clk) disable iff (rst)
    (q_level == bblur_pkg::QLVL_W'(bblur_pkg::QUEUE_DEPTH) && !q_pop) |=>
    (q_level == bblur_pkg::QLVL_W'(bblur_pkg::QUEUE_DEPTH)))
    else $error("full queue changed level without a pop");
`endif

endmodule
